FILE: sv/rpa_pkg.sv
package rpa_pkg;

    localparam int ADDR_W   = 27;
    localparam int CFG_W    = 16;
    localparam int FREE_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_DROP  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_OOM  = 3'd1,
        ST_BAD  = 3'd2,
        ST_UNDR = 3'd3,
        ST_SAT  = 3'd4,
        ST_FULL = 3'd5
    } t_status;

    typedef struct packed {
        logic    wr_ref;
        logic    push;
        logic    pop;
        logic    take_fresh;
        t_status status;
    } t_ref_ctl;

endpackage

FILE: sv/refcounted_page_allocator_core.sv
// Page allocator with per-page reference counts. Each command runs in two
// steps: one reads the count table (and the free stack for an allocate
// that pops it), one, once the output is free, updates both and registers
// the result; the next command is taken while a result still waits on the
// output. After reset the count table is swept to zero, one entry per
// cycle, so commands are accepted only after the sweep; first_page writes
// are taken at any time. Pages are handed out from the free stack first,
// then from the never-used region top down; free_pages counts both.
module refcounted_page_allocator_core #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int REF_BITS   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rpa_pkg::CFG_W-1:0]      i_first_page,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [rpa_pkg::ADDR_W-1:0]     i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rpa_pkg::ADDR_W-1:0]     o_page_address,
    output logic [rpa_pkg::COUNT_W-1:0]    o_ref_count,
    output logic [rpa_pkg::FREE_W-1:0]     o_free_pages,
    output logic [rpa_pkg::STATUS_W-1:0]   o_status
);

    localparam int PIDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                       r_state, n_state;
    logic [PIDX_W-1:0]            r_clr, n_clr;
    logic [rpa_pkg::CFG_W-1:0]    r_first_page, n_first_page;
    logic [CNT_W-1:0]             r_sd, n_sd;
    logic [CNT_W-1:0]             r_fresh, n_fresh;
    rpa_pkg::t_cmd                r_cmd, n_cmd;
    logic                         r_bad, n_bad;
    logic                         r_pop, n_pop;
    logic                         r_fresh_ok, n_fresh_ok;
    logic [PIDX_W-1:0]            r_page, n_page;
    logic                         r_out_valid, n_out_valid;
    logic [rpa_pkg::ADDR_W-1:0]   r_page_address, n_page_address;
    logic [rpa_pkg::COUNT_W-1:0]  r_ref_count, n_ref_count;
    logic [rpa_pkg::FREE_W-1:0]   r_free_pages, n_free_pages;
    rpa_pkg::t_status             r_status, n_status;

    logic                         accept;
    logic                         exec_go;
    rpa_pkg::t_cmd                cmd_in;
    logic [31:0]                  pidx32;
    logic [31:0]                  fresh_pg32;
    logic [31:0]                  used_now, used_next;
    logic [31:0]                  left_now, left_next;
    logic [31:0]                  free32;
    logic [31:0]                  count32;
    logic [CNT_W-1:0]             sd_m1;
    logic [PIDX_W-1:0]            page_sel;
    logic [PIDX_W+PAGE_SHIFT+rpa_pkg::ADDR_W-1:0] page_addr_wide;

    logic                         ref_wr_en;
    logic [PIDX_W-1:0]            ref_wr_addr;
    logic [REF_BITS-1:0]          ref_wr_data;
    logic [REF_BITS-1:0]          ref_rd_data;
    logic                         stk_rd_en;
    logic [PIDX_W-1:0]            stk_rd_data;
    logic                         stk_wr_en;

    logic [REF_BITS-1:0]          new_count;
    logic [REF_BITS-1:0]          res_count;
    rpa_pkg::t_ref_ctl            ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign cmd_in     = rpa_pkg::t_cmd'(i_cmd);
    assign pidx32     = 32'(i_address >> PAGE_SHIFT);
    assign fresh_pg32 = 32'(NUM_PAGES - 1) - 32'(r_fresh);
    assign sd_m1      = r_sd - CNT_W'(1);

    always_comb begin
        used_now  = 32'(r_first_page) + 32'(r_fresh);
        used_next = 32'(r_first_page) + 32'(n_fresh);
        left_now  = (used_now >= 32'(NUM_PAGES)) ? 32'd0 : 32'(NUM_PAGES) - used_now;
        left_next = (used_next >= 32'(NUM_PAGES)) ? 32'd0 : 32'(NUM_PAGES) - used_next;
        free32    = 32'(n_sd) + left_next;
    end

    assign page_sel = (r_cmd == rpa_pkg::CMD_ALLOC && r_pop) ? stk_rd_data : r_page;
    assign page_addr_wide = {{rpa_pkg::ADDR_W{1'b0}}, page_sel, {PAGE_SHIFT{1'b0}}};
    assign count32 = 32'(res_count);

    rpa_refcalc #(
        .REF_BITS(REF_BITS)
    ) u_refcalc (
        .i_cmd        (r_cmd),
        .i_bad        (r_bad),
        .i_can_pop    (r_pop),
        .i_can_fresh  (r_fresh_ok),
        .i_stack_full (32'(r_sd) >= 32'(NUM_PAGES)),
        .i_count      (ref_rd_data),
        .o_new_count  (new_count),
        .o_count      (res_count),
        .o_ctl        (ctl)
    );

    always_comb begin
        if (r_state == S_CLEAR) begin
            ref_wr_en   = 1'b1;
            ref_wr_addr = r_clr;
            ref_wr_data = '0;
        end else begin
            ref_wr_en   = exec_go && ctl.wr_ref;
            ref_wr_addr = page_sel;
            ref_wr_data = new_count;
        end
    end

    assign stk_rd_en = accept && (cmd_in == rpa_pkg::CMD_ALLOC) && (r_sd != '0);
    assign stk_wr_en = exec_go && ctl.push;

    rpa_ram #(
        .WIDTH(REF_BITS),
        .DEPTH(NUM_PAGES)
    ) u_ref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ref_wr_en),
        .i_wr_addr (ref_wr_addr),
        .i_wr_data (ref_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (n_page),
        .o_rd_data (ref_rd_data)
    );

    rpa_ram #(
        .WIDTH(PIDX_W),
        .DEPTH(NUM_PAGES)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (r_sd[PIDX_W-1:0]),
        .i_wr_data (r_page),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (sd_m1[PIDX_W-1:0]),
        .o_rd_data (stk_rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_first_page   = i_cfg_valid ? i_first_page : r_first_page;
        n_sd           = r_sd;
        n_fresh        = r_fresh;
        n_cmd          = r_cmd;
        n_bad          = r_bad;
        n_pop          = r_pop;
        n_fresh_ok     = r_fresh_ok;
        n_page         = r_page;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_page_address = r_page_address;
        n_ref_count    = r_ref_count;
        n_free_pages   = r_free_pages;
        n_status       = r_status;
        if (cmd_in == rpa_pkg::CMD_ALLOC) begin
            n_page = fresh_pg32[PIDX_W-1:0];
        end else begin
            n_page = pidx32[PIDX_W-1:0];
        end
        if (!accept) begin
            n_page = r_page;
        end
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + PIDX_W'(1);
                if (32'(r_clr) == 32'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = cmd_in;
                    n_bad      = (cmd_in != rpa_pkg::CMD_ALLOC) &&
                                 ((i_address[PAGE_SHIFT-1:0] != '0) ||
                                  (pidx32 < 32'(r_first_page)) ||
                                  (pidx32 >= 32'(NUM_PAGES)));
                    n_pop      = (r_sd != '0);
                    n_fresh_ok = (left_now != 32'd0);
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    if (ctl.push) begin
                        n_sd = r_sd + CNT_W'(1);
                    end else if (ctl.pop) begin
                        n_sd = sd_m1;
                    end
                    if (ctl.take_fresh) begin
                        n_fresh = r_fresh + CNT_W'(1);
                    end
                    n_out_valid    = 1'b1;
                    n_page_address = (r_cmd == rpa_pkg::CMD_ALLOC && ctl.status == rpa_pkg::ST_OK)
                                     ? page_addr_wide[rpa_pkg::ADDR_W-1:0] : '0;
                    n_ref_count    = count32[rpa_pkg::COUNT_W-1:0];
                    n_free_pages   = free32[rpa_pkg::FREE_W-1:0];
                    n_status       = ctl.status;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_first_page <= '0;
            r_sd         <= '0;
            r_fresh      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_first_page <= n_first_page;
            r_sd         <= n_sd;
            r_fresh      <= n_fresh;
            r_out_valid  <= n_out_valid;
        end
        r_cmd          <= n_cmd;
        r_bad          <= n_bad;
        r_pop          <= n_pop;
        r_fresh_ok     <= n_fresh_ok;
        r_page         <= n_page;
        r_page_address <= n_page_address;
        r_ref_count    <= n_ref_count;
        r_free_pages   <= n_free_pages;
        r_status       <= n_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_page_address;
    assign o_ref_count    = r_ref_count;
    assign o_free_pages   = r_free_pages;
    assign o_status       = r_status;

    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_bad) |-> !ref_wr_en)
        else $error("count table written for a bad address");

    a_sd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sd) <= 32'(NUM_PAGES))
        else $error("free stack depth beyond page count");

    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |-> !(ctl.push && ctl.pop))
        else $error("push and pop in one transfer");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && r_cmd == rpa_pkg::CMD_ALLOC && ctl.status == rpa_pkg::ST_OK)
        |=> (o_ref_count == rpa_pkg::COUNT_W'(1)))
        else $error("allocated page count is not one");

endmodule

FILE: sv/rpa_ram.sv
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/rpa_refcalc.sv
module rpa_refcalc #(
    parameter int REF_BITS = 8
) (
    input  rpa_pkg::t_cmd        i_cmd,
    input  logic                 i_bad,
    input  logic                 i_can_pop,
    input  logic                 i_can_fresh,
    input  logic                 i_stack_full,
    input  logic [REF_BITS-1:0]  i_count,
    output logic [REF_BITS-1:0]  o_new_count,
    output logic [REF_BITS-1:0]  o_count,
    output rpa_pkg::t_ref_ctl    o_ctl
);

    always_comb begin
        o_new_count       = i_count;
        o_count           = i_count;
        o_ctl.wr_ref      = 1'b0;
        o_ctl.push        = 1'b0;
        o_ctl.pop         = 1'b0;
        o_ctl.take_fresh  = 1'b0;
        o_ctl.status      = rpa_pkg::ST_OK;
        unique case (i_cmd)
            rpa_pkg::CMD_ALLOC: begin
                o_new_count = REF_BITS'(1);
                o_count     = REF_BITS'(1);
                if (i_can_pop) begin
                    o_ctl.pop    = 1'b1;
                    o_ctl.wr_ref = 1'b1;
                end else if (i_can_fresh) begin
                    o_ctl.take_fresh = 1'b1;
                    o_ctl.wr_ref     = 1'b1;
                end else begin
                    o_count      = '0;
                    o_ctl.status = rpa_pkg::ST_OOM;
                end
            end
            rpa_pkg::CMD_DROP: begin
                priority if (i_bad) begin
                    o_count      = '0;
                    o_ctl.status = rpa_pkg::ST_BAD;
                end else if (i_count == '0) begin
                    o_ctl.status = rpa_pkg::ST_UNDR;
                end else if (i_count == REF_BITS'(1) && i_stack_full) begin
                    o_ctl.status = rpa_pkg::ST_FULL;
                end else begin
                    o_new_count  = i_count - REF_BITS'(1);
                    o_count      = o_new_count;
                    o_ctl.wr_ref = 1'b1;
                    o_ctl.push   = (i_count == REF_BITS'(1));
                end
            end
            rpa_pkg::CMD_ADD: begin
                priority if (i_bad) begin
                    o_count      = '0;
                    o_ctl.status = rpa_pkg::ST_BAD;
                end else if (i_count == '1) begin
                    o_ctl.status = rpa_pkg::ST_SAT;
                end else begin
                    o_new_count  = i_count + REF_BITS'(1);
                    o_count      = o_new_count;
                    o_ctl.wr_ref = 1'b1;
                end
            end
            rpa_pkg::CMD_READ: begin
                if (i_bad) begin
                    o_count      = '0;
                    o_ctl.status = rpa_pkg::ST_BAD;
                end
            end
            default: begin
                o_ctl.status = rpa_pkg::ST_OK;
            end
        endcase
    end

endmodule
